/* rtl/firmware_image_section_packetizer_defines.svh */
// Assertion macros shared by the packetizer checker.
// No dependencies; included by the checker file only.
`ifndef FIRMWARE_IMAGE_SECTION_PACKETIZER_DEFINES_SVH
`define FIRMWARE_IMAGE_SECTION_PACKETIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FWSP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fwsp check failed");

// Next-cycle implication, disabled while in reset
`define FWSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fwsp check failed");

`endif

/* rtl/fwsp_pkg.sv */
// Types and constants for the firmware image section packetizer.
// No dependencies; used by the top level, fwsp_core and fwsp_out_reg by scoped names.
package fwsp_pkg;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_DESC = 2'd1,
        PH_BODY = 2'd2,
        PH_END  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        JOB_HDR    = 2'd0,
        JOB_BODY   = 2'd1,
        JOB_BYTE   = 2'd2,
        JOB_STATUS = 2'd3
    } job_kind_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_MANY = 2'd2;

    localparam logic [12:0] CHUNK_RESET = 13'd2020;
    localparam logic [12:0] CHUNK_MAX   = 13'd4096;

    localparam logic [7:0] TXD_FLAG_HDR  = 8'h0C;
    localparam logic [7:0] TXD_FLAG_BODY = 8'h1C;
    localparam logic [7:0] CMD_ID        = 8'h0D;

    // result item handed from the core to the output register
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
        logic       run_last;
        logic       done_res;
        logic [1:0] status;
    } res_t;

endpackage

/* rtl/firmware_image_section_packetizer.sv */
// Top level of the firmware image section packetizer.
// Depends on fwsp_pkg, fwsp_core and fwsp_out_reg.
//
//  channel | dir | fields
//  s_      | in  | tdata[7:0] image_byte, tlast image_last
//  m_      | out | tdata: out_byte, packet_start, packet_end, done_res, status;
//          |     | tlast run_last, tuser byte_valid
//  cfg_    | in  | chunk_bytes, written when cfg_wr_en is high
//
// One result leaves per cycle, and an input transfer that causes one result or
// none is taken every cycle, while the output takes them. The header byte that
// completes the fixed header, or a byte that opens a body chunk, holds the input
// until its burst has left: the result sequencer emits it one byte a cycle.
// Reset (aresetn low, synchronous) clears all image state; chunk_bytes -> 2020.
// Output stalls hold the result in the output register and back up the input.
module firmware_image_section_packetizer #(
    parameter int MAX_SECTIONS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] image_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [8] packet_start, [9] packet_end,
                                    // [10] done_res, [12:11] status
    output logic        m_tlast,
    output logic [0:0]  m_tuser     // [0] byte_valid
);

    logic [12:0]    chunk_reg;
    logic [12:0]    chunk_eff;
    logic           res_valid;
    logic           res_ready;
    fwsp_pkg::res_t res;

    // chunk size register
    always_ff @(posedge aclk) begin
        if (!aresetn) chunk_reg <= fwsp_pkg::CHUNK_RESET;
        else if (cfg_wr_en) chunk_reg <= cfg_wr_data;
    end

    // zero acts as one, anything above the limit as the limit
    assign chunk_eff = (chunk_reg == 13'd0) ? 13'd1 :
                       (chunk_reg > fwsp_pkg::CHUNK_MAX) ? fwsp_pkg::CHUNK_MAX : chunk_reg;

    fwsp_core #(
        .MAX_SECTIONS(MAX_SECTIONS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .chunk_eff (chunk_eff),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    fwsp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/fwsp_core.sv */
// Packetizer core: image state, section length store and result sequencer.
// Depends on fwsp_pkg.
module fwsp_core #(
    parameter int MAX_SECTIONS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [12:0]       chunk_eff,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              res_valid,
    input  logic              res_ready,
    output fwsp_pkg::res_t    res
);

    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    // image state
    fwsp_pkg::phase_t phase_reg, phase_next;
    logic [12:0]   pos_reg, pos_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [23:0]   dw_reg, dw_next;
    logic [AW:0]   idx_reg, idx_next;
    logic [AW:0]   nz_reg, nz_next;
    logic [24:0]   rem_reg, rem_next;
    logic [12:0]   chk_reg, chk_next;
    logic [1:0]    err_reg, err_next;

    logic [7:0]    hdr_buf [32];
    logic          hdr_we;

    // section length store, non-zero sections only, in order
    logic [24:0]   len_mem [MAX_SECTIONS];
    logic [24:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [24:0]   sz;

    // result job
    logic                  job_valid_reg;
    fwsp_pkg::job_kind_t   job_kind_reg, jk;
    logic [5:0]            job_cnt_reg;
    logic [7:0]            job_byte_reg;
    logic [12:0]           job_plen_reg, jplen;
    logic [12:0]           job_hlen_reg, jhlen;
    logic                  job_end_reg, jend;
    logic                  job_last_reg, jlast;
    logic [1:0]            job_stat_reg, jstat;
    logic                  job_nosec_reg, jnosec;
    logic                  job_load;
    logic                  job_final;

    logic          s_fire;
    logic [11:0]   last_off;
    logic [12:0]   c;
    logic [12:0]   chk_dec;
    logic [AW:0]   idx_inc;
    logic [AW:0]   rd_idx;
    logic [7:0]    hcount;

    assign s_fire   = in_valid && in_ready;
    assign last_off = {cnt_reg, 4'b0} - 12'd1;
    assign idx_inc  = idx_reg + 1'b1;
    assign hcount   = hdr_buf[25];
    // prefetch the length of the section after the one that is current next cycle
    assign rd_idx   = idx_next + 1'b1;
    assign rd_addr  = (phase_next == fwsp_pkg::PH_BODY) ? rd_idx[AW-1:0] : '0;
    assign sz       = {1'b0, dw_reg[23:16], dw_reg[15:8], dw_reg[7:0]}
                      + (in_byte[4] ? 25'd8 : 25'd0);
    assign c        = (rem_reg > {12'b0, chunk_eff}) ? chunk_eff : rem_reg[12:0];

    // step of the image state for one accepted transfer
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        dw_next    = dw_reg;
        idx_next   = idx_reg;
        nz_next    = nz_reg;
        rem_next   = rem_reg;
        chk_next   = chk_reg;
        err_next   = err_reg;
        hdr_we     = 1'b0;
        mem_we     = 1'b0;
        job_load   = 1'b0;
        jk         = fwsp_pkg::JOB_STATUS;
        jplen      = '0;
        jhlen      = '0;
        jend       = 1'b0;
        jlast      = 1'b0;
        jstat      = fwsp_pkg::ST_OK;
        jnosec     = 1'b0;
        chk_dec    = '0;
        if (s_fire) begin
            case (phase_reg)
                fwsp_pkg::PH_HDR: begin
                    hdr_we   = 1'b1;
                    pos_next = pos_reg + 13'd1;
                    if (pos_reg == 13'd31) begin
                        cnt_next = hcount;
                        if (hcount > 8'(MAX_SECTIONS)) begin
                            if (err_reg == fwsp_pkg::ST_OK) err_next = fwsp_pkg::ST_MANY;
                            phase_next = fwsp_pkg::PH_END;
                        end else begin
                            job_load   = 1'b1;
                            jk         = fwsp_pkg::JOB_HDR;
                            jhlen      = 13'd32 + {1'b0, hcount, 4'b0};
                            jplen      = 13'd40 + {1'b0, hcount, 4'b0};
                            jnosec     = (hcount == 8'd0);
                            pos_next   = '0;
                            phase_next = (hcount == 8'd0) ? fwsp_pkg::PH_END
                                                          : fwsp_pkg::PH_DESC;
                        end
                    end
                end
                fwsp_pkg::PH_DESC: begin
                    case (pos_reg[3:0])
                        4'd4: dw_next = {16'b0, in_byte};
                        4'd5: dw_next[15:8] = in_byte;
                        4'd6: dw_next[23:16] = in_byte;
                        4'd7: begin
                            if (sz != 25'd0) begin
                                mem_we  = 1'b1;
                                nz_next = nz_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    job_load = 1'b1;
                    jk       = fwsp_pkg::JOB_BYTE;
                    jend     = (pos_reg == {1'b0, last_off});
                    pos_next = pos_reg + 13'd1;
                    if (jend) begin
                        if (nz_reg == '0) begin
                            phase_next = fwsp_pkg::PH_END;
                        end else begin
                            phase_next = fwsp_pkg::PH_BODY;
                            idx_next   = '0;
                            rem_next   = rd_data_reg;
                            chk_next   = '0;
                        end
                    end
                end
                fwsp_pkg::PH_BODY: begin
                    job_load = 1'b1;
                    if (chk_reg == 13'd0) begin
                        jk       = fwsp_pkg::JOB_BODY;
                        jplen    = 13'd8 + c;
                        chk_dec  = c - 13'd1;
                        rem_next = rem_reg - {12'b0, c};
                    end else begin
                        jk      = fwsp_pkg::JOB_BYTE;
                        chk_dec = chk_reg - 13'd1;
                    end
                    chk_next = chk_dec;
                    jend     = (chk_dec == 13'd0);
                    if (jend && rem_next == 25'd0) begin
                        if (idx_inc >= nz_reg) begin
                            phase_next = fwsp_pkg::PH_END;
                        end else begin
                            idx_next = idx_inc;
                            rem_next = rd_data_reg;
                            chk_next = '0;
                        end
                    end
                end
                default: begin
                    if (err_reg == fwsp_pkg::ST_OK) err_next = fwsp_pkg::ST_LEN;
                end
            endcase
            // end of image: status and clear
            if (in_last) begin
                if (phase_next != fwsp_pkg::PH_END && err_next == fwsp_pkg::ST_OK)
                    err_next = fwsp_pkg::ST_LEN;
                if (!job_load) begin
                    job_load = 1'b1;
                    jk       = fwsp_pkg::JOB_STATUS;
                end
                jlast      = 1'b1;
                jstat      = err_next;
                phase_next = fwsp_pkg::PH_HDR;
                pos_next   = '0;
                cnt_next   = '0;
                dw_next    = '0;
                idx_next   = '0;
                nz_next    = '0;
                rem_next   = '0;
                chk_next   = '0;
                err_next   = fwsp_pkg::ST_OK;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fwsp_pkg::PH_HDR;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            dw_reg    <= '0;
            idx_reg   <= '0;
            nz_reg    <= '0;
            rem_reg   <= '0;
            chk_reg   <= '0;
            err_reg   <= fwsp_pkg::ST_OK;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            dw_reg    <= dw_next;
            idx_reg   <= idx_next;
            nz_reg    <= nz_next;
            rem_reg   <= rem_next;
            chk_reg   <= chk_next;
            err_reg   <= err_next;
        end
    end

    // header buffer and length store
    always_ff @(posedge aclk) begin
        if (hdr_we) hdr_buf[pos_reg[4:0]] <= in_byte;
        if (mem_we) len_mem[nz_reg[AW-1:0]] <= sz;
        rd_data_reg <= len_mem[rd_addr];
    end

    assign job_final = (job_kind_reg == fwsp_pkg::JOB_HDR)  ? (job_cnt_reg == 6'd63) :
                       (job_kind_reg == fwsp_pkg::JOB_BODY) ? (job_cnt_reg == 6'd32) :
                       1'b1;
    assign res_valid = job_valid_reg;
    assign in_ready  = !job_valid_reg || (job_final && res_ready);

    // job register: one result per cycle while the output side takes them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_cnt_reg   <= '0;
        end else if (job_load) begin
            job_valid_reg <= 1'b1;
            job_cnt_reg   <= '0;
        end else if (job_valid_reg && res_ready) begin
            if (job_final) job_valid_reg <= 1'b0;
            job_cnt_reg <= job_cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_kind_reg  <= jk;
            job_byte_reg  <= in_byte;
            job_plen_reg  <= jplen;
            job_hlen_reg  <= jhlen;
            job_end_reg   <= jend;
            job_last_reg  <= jlast;
            job_stat_reg  <= jstat;
            job_nosec_reg <= jnosec;
        end
    end

    // byte of the current result
    always_comb begin
        res = '0;
        res.byte_valid = (job_kind_reg != fwsp_pkg::JOB_STATUS);
        case (job_kind_reg)
            fwsp_pkg::JOB_HDR, fwsp_pkg::JOB_BODY: begin
                if (job_cnt_reg < 6'd24) begin
                    res.packet_start = (job_cnt_reg == 6'd0);
                    if (job_cnt_reg == 6'd2)
                        res.out_byte = (job_kind_reg == fwsp_pkg::JOB_BODY)
                                       ? fwsp_pkg::TXD_FLAG_BODY : fwsp_pkg::TXD_FLAG_HDR;
                    else if (job_cnt_reg == 6'd8)
                        res.out_byte = job_plen_reg[7:0];
                    else if (job_cnt_reg == 6'd9)
                        res.out_byte = {3'b0, job_plen_reg[12:8]};
                end else if (job_kind_reg == fwsp_pkg::JOB_BODY) begin
                    if (job_cnt_reg == 6'd32) begin
                        res.out_byte   = job_byte_reg;
                        res.packet_end = job_end_reg;
                    end
                end else if (job_cnt_reg < 6'd32) begin
                    // command header
                    if (job_cnt_reg == 6'd24) res.out_byte = fwsp_pkg::CMD_ID;
                    else if (job_cnt_reg == 6'd28) res.out_byte = job_hlen_reg[7:0];
                    else if (job_cnt_reg == 6'd29) res.out_byte = {3'b0, job_hlen_reg[12:8]};
                end else begin
                    // fixed header, dword 7 low half patched to the chunk size
                    if (job_cnt_reg[4:0] == 5'd28) res.out_byte = chunk_eff[7:0];
                    else if (job_cnt_reg[4:0] == 5'd29) res.out_byte = {3'b0, chunk_eff[12:8]};
                    else res.out_byte = hdr_buf[job_cnt_reg[4:0]];
                    res.packet_end = (job_cnt_reg == 6'd63) && job_nosec_reg;
                end
            end
            fwsp_pkg::JOB_BYTE: begin
                res.out_byte   = job_byte_reg;
                res.packet_end = job_end_reg;
            end
            default: ;
        endcase
        res.run_last = job_final;
        res.done_res = job_final && job_last_reg;
        res.status   = (job_final && job_last_reg) ? job_stat_reg : fwsp_pkg::ST_OK;
    end

endmodule

/* rtl/fwsp_out_reg.sv */
// Output register: holds one result and packs it onto the master stream.
// Depends on fwsp_pkg.
module fwsp_out_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  fwsp_pkg::res_t  in_res,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic            m_tlast,
    output logic [0:0]      m_tuser
);

    logic           valid_reg;
    fwsp_pkg::res_t data_reg;

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (in_ready) valid_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) data_reg <= in_res;
    end

    // field packing
    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b0, data_reg.status, data_reg.done_res, data_reg.packet_end,
                       data_reg.packet_start, data_reg.out_byte};
    assign m_tlast  = data_reg.run_last;
    assign m_tuser  = data_reg.byte_valid;

endmodule

/* rtl/fwsp_checker.sv */
// Port-level checks on the packetizer result stream, bound to the top level.
// Depends on firmware_image_section_packetizer_defines.svh.
`include "firmware_image_section_packetizer_defines.svh"

module fwsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic [0:0]  m_tuser
);

    // a stalled transfer stays offered
    `FWSP_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // status-only result closes its run
    `FWSP_ASSERT_NOW(a_status_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast)
    // done marks only the last result of a run
    `FWSP_ASSERT_NOW(a_done_last, aclk, aresetn, m_tvalid && m_tdata[10], m_tlast)
    // non-zero status only with done
    `FWSP_ASSERT_NOW(a_status_done, aclk, aresetn, m_tvalid && (m_tdata[12:11] != 2'd0),
        m_tdata[10])

endmodule

bind firmware_image_section_packetizer fwsp_checker u_fwsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
